[hdl/apsp_pkg.sv]
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared widths, codes and the controller-to-datapath command for the
// all-pairs shortest path block.
// ----------------------------------------------------------------------------
package apsp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int ADDR_W       = 2 * IDX_W;
  localparam int CELLS        = MAX_VERTICES * MAX_VERTICES;
  localparam int CNT_W        = 5;
  localparam int DIST_W       = 17;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;

  localparam logic [DIST_W-1:0] NO_PATH     = DIST_W'(99999);
  localparam logic [CNT_W-1:0]  VCOUNT_RST  = CNT_W'(16);
  localparam logic [CNT_W-1:0]  SIDE_MAX    = CNT_W'(MAX_VERTICES);
  localparam logic [IDX_W:0]    SIDE        = (IDX_W + 1)'(MAX_VERTICES);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef struct packed {
    logic             host_wr;
    logic             host_rd;
    logic             emit;
    logic             run_init;
    logic             rd_ik;
    logic             latch_ik;
    logic             rd_pair;
    logic             relax;
    logic             scan_rd;
    logic             scan_upd;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } cmd_t;

endpackage

[hdl/apsp_ctrl.sv]
// ----------------------------------------------------------------------------
// apsp_ctrl
// Sequencer for host accesses, the relaxation sweep over k, i, j and the
// final scan for the largest finite and the smallest distance.
// ----------------------------------------------------------------------------
module apsp_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [1:0]                in_op,
  input  logic [apsp_pkg::CNT_W-1:0] vertex_count,
  output logic                      busy,
  output apsp_pkg::cmd_t            cmd
);
  import apsp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_IK   = 8'b0000_0010,
    S_IKL  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_UPD  = 8'b0001_0000,
    S_SRD  = 8'b0010_0000,
    S_SCMP = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] side;
  logic [CNT_W-1:0] last;
  logic             j_last;
  logic             i_last;
  logic             k_last;

  assign side   = (vertex_count > SIDE_MAX) ? SIDE_MAX : vertex_count;
  assign last   = side - CNT_W'(1);
  assign j_last = ({1'b0, j_r} == last);
  assign i_last = ({1'b0, i_r} == last);
  assign k_last = ({1'b0, k_r} == last);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cmd       = '0;
    cmd.k     = k_r;
    cmd.i     = i_r;
    cmd.j     = j_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_op)
            OP_WRITE: begin
              cmd.host_wr = 1'b1;
              cmd.emit    = 1'b1;
            end
            OP_READ: begin
              cmd.host_rd = 1'b1;
              cmd.emit    = 1'b1;
            end
            OP_RUN: begin
              cmd.run_init = 1'b1;
              k_nxt        = '0;
              i_nxt        = '0;
              j_nxt        = '0;
              state_nxt    = (side == '0) ? S_DONE : S_IK;
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      S_IK: begin
        cmd.rd_ik = 1'b1;
        state_nxt = S_IKL;
      end
      S_IKL: begin
        cmd.latch_ik = 1'b1;
        state_nxt    = S_RD;
      end
      S_RD: begin
        cmd.rd_pair = 1'b1;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        cmd.relax = 1'b1;
        if (!j_last) begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_RD;
        end else begin
          j_nxt = '0;
          if (!i_last) begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_IK;
          end else begin
            i_nxt = '0;
            if (!k_last) begin
              k_nxt     = k_r + IDX_W'(1);
              state_nxt = S_IK;
            end else begin
              k_nxt     = '0;
              state_nxt = S_SRD;
            end
          end
        end
      end
      S_SRD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCMP;
      end
      S_SCMP: begin
        cmd.scan_upd = 1'b1;
        if (!j_last) begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_SRD;
        end else begin
          j_nxt = '0;
          if (!i_last) begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_SRD;
          end else begin
            i_nxt     = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

[hdl/apsp_dp.sv]
// ----------------------------------------------------------------------------
// apsp_dp
// Distance matrix memory with two registered read ports, the relaxation
// adder and compare, the extreme-value scan and the result registers.
// ----------------------------------------------------------------------------
module apsp_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  apsp_pkg::cmd_t              cmd,
  input  logic [3:0]                  in_row,
  input  logic [3:0]                  in_col,
  input  logic [apsp_pkg::DIST_W-1:0] in_distance,
  output logic                        out_strobe,
  output logic [apsp_pkg::DIST_W-1:0] out_entry_distance,
  output logic [apsp_pkg::DIST_W-1:0] out_max_finite,
  output logic [apsp_pkg::DIST_W-1:0] out_min_distance
);
  import apsp_pkg::*;

  logic [DIST_W-1:0] dist_mem_r [CELLS];
  logic [DIST_W-1:0] rdata_a_r;
  logic [DIST_W-1:0] rdata_b_r;
  logic [DIST_W-1:0] dik_r;
  logic [DIST_W-1:0] max_r, max_nxt;
  logic [DIST_W-1:0] min_r, min_nxt;
  logic              strobe_r;
  logic              rd_hit_r;

  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [ADDR_W-1:0] waddr;
  logic [DIST_W-1:0] wdata;
  logic              we;
  logic              in_range;
  logic [DIST_W:0]   via;
  logic [DIST_W-1:0] clipped;

  assign in_range = ({1'b0, in_row} < SIDE) && ({1'b0, in_col} < SIDE);
  assign clipped  = (in_distance > NO_PATH) ? NO_PATH : in_distance;
  assign via      = {1'b0, dik_r} + {1'b0, rdata_a_r};
  assign raddr_a  = cmd.rd_ik ? {cmd.i, cmd.k} : {cmd.k, cmd.j};
  assign raddr_b  = cmd.host_rd ? {in_row, in_col} : {cmd.i, cmd.j};

  always_comb begin
    we    = 1'b0;
    waddr = {cmd.i, cmd.j};
    wdata = via[DIST_W-1:0];
    if (cmd.host_wr) begin
      we    = in_range;
      waddr = {in_row, in_col};
      wdata = clipped;
    end else if (cmd.relax) begin
      we = (via < {1'b0, rdata_b_r});
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      dist_mem_r[waddr] <= wdata;
    end
    if (cmd.rd_ik || cmd.rd_pair) begin
      rdata_a_r <= dist_mem_r[raddr_a];
    end
    if (cmd.host_rd || cmd.rd_pair || cmd.scan_rd) begin
      rdata_b_r <= dist_mem_r[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_ik) begin
      dik_r <= rdata_a_r;
    end
  end

  always_comb begin
    max_nxt = max_r;
    min_nxt = min_r;
    if (cmd.run_init) begin
      max_nxt = '0;
      min_nxt = NO_PATH;
    end else if (cmd.scan_upd) begin
      if ((rdata_b_r != NO_PATH) && (rdata_b_r >= max_r)) begin
        max_nxt = rdata_b_r;
      end
      if (rdata_b_r <= min_r) begin
        min_nxt = rdata_b_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r    <= '0;
      min_r    <= NO_PATH;
      strobe_r <= 1'b0;
      rd_hit_r <= 1'b0;
    end else begin
      max_r    <= max_nxt;
      min_r    <= min_nxt;
      strobe_r <= cmd.emit;
      rd_hit_r <= cmd.host_rd && in_range;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_entry_distance = rd_hit_r ? rdata_b_r : '0;
  assign out_max_finite     = max_r;
  assign out_min_distance   = min_r;

endmodule

[hdl/all_pairs_shortest_path.sv]
// ----------------------------------------------------------------------------
// all_pairs_shortest_path
// Distance matrix store with an in-place all-pairs shortest path engine.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low. Its fields are
// in_op, in_row, in_col and in_distance. Every command returns one result,
// shown for a single cycle with out_strobe high in the cycle after the transfer
// for writes, reads and the unused op code, so these run one per cycle.
// The receiver cannot stall; the result must be taken in that cycle.
// A run holds busy high, and its result appears in the cycle busy falls. The
// matrix has a single write port: each relaxation reads, adds, compares and
// writes back one entry, each row first fetches its entry in column k, and
// the final scan then reads the entries one at a time.
// vertex_count is written through the cfg_ APB port at byte address 0; the user
// must do so only while idle (the block does not enforce it). Values above 16 act as 16.
// Reset (rst_n low, synchronous) sets vertex_count to 16, the largest finite
// distance to 0 and the smallest distance to 99999. Matrix entries hold
// nothing defined until written.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_op,
  input  logic [3:0]                      in_row,
  input  logic [3:0]                      in_col,
  input  logic [apsp_pkg::DIST_W-1:0]     in_distance,
  output logic                            out_strobe,
  output logic [apsp_pkg::DIST_W-1:0]     out_entry_distance,
  output logic [apsp_pkg::DIST_W-1:0]     out_max_finite,
  output logic [apsp_pkg::DIST_W-1:0]     out_min_distance,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [apsp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [apsp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [apsp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import apsp_pkg::*;

  logic [CNT_W-1:0] vertex_count_r;
  logic             reg_sel;
  logic             cfg_wr;
  cmd_t             cmd;

  assign reg_sel    = (cfg_paddr[2] == REG_VERTEX_COUNT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? {{(CFG_DATA_W - CNT_W){1'b0}}, vertex_count_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCOUNT_RST;
    end else if (cfg_wr && reg_sel) begin
      vertex_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  apsp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_op        (in_op),
    .vertex_count (vertex_count_r),
    .busy         (busy),
    .cmd          (cmd)
  );

  apsp_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_row             (in_row),
    .in_col             (in_col),
    .in_distance        (in_distance),
    .out_strobe         (out_strobe),
    .out_entry_distance (out_entry_distance),
    .out_max_finite     (out_max_finite),
    .out_min_distance   (out_min_distance)
  );

endmodule

[hdl/apsp_checker.sv]
// ----------------------------------------------------------------------------
// apsp_checker
// Port-level checks on command transfers and result timing, bound to the
// top level.
// ----------------------------------------------------------------------------
module apsp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  in_op,
  input logic                        out_strobe,
  input logic [apsp_pkg::DIST_W-1:0] out_entry_distance
);
  import apsp_pkg::*;

  logic accepted;

  assign accepted = start && !busy;

  // A transfer that is not a run is answered in the next cycle without stalling.
  assert property (@(posedge clk) disable iff (!rst_n)
    accepted && (in_op != OP_RUN) |=> out_strobe && !busy)
    else $error("short command not answered in the next cycle");

  // A run holds the command port off in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    accepted && (in_op == OP_RUN) |=> busy && !out_strobe)
    else $error("run did not raise busy");

  // The end of a run is marked by its result.
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_strobe)
    else $error("run ended without a result");

  // A nonzero entry distance only follows a read transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_entry_distance != '0) |->
      $past(start) && !$past(busy) && ($past(in_op) == OP_READ))
    else $error("entry distance without a read");

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (.*);
